FILE: rtl/mrf_pkg.sv
`timescale 1ns / 1ps

package mrf_pkg;

    localparam int unsigned RATE_COUNT = 9;
    localparam int unsigned TICK_W     = 32;
    localparam int unsigned FLAG_W     = RATE_COUNT;
    localparam int unsigned CHAN_W     = 4;

    localparam int unsigned TICK_RATE_DEF    = 1000;
    localparam int unsigned NUM_CHANNELS_DEF = 9;

    // release rates in Hz, fastest first
    localparam int unsigned RATE_TABLE [RATE_COUNT] = '{
        1000, 500, 250, 100, 50, 20, 10, 4, 1
    };

    typedef enum logic {
        OP_INIT = 1'b0,
        OP_RUN  = 1'b1
    } t_op;

    typedef struct packed {
        logic load;
        logic run;
    } t_cell_ctrl;

endpackage

FILE: rtl/multirate_release_flags_core.sv
`timescale 1ns / 1ps
// channel  | direction | handshake            | payload
// request  | in        | i_valid / o_stall    | i_op, i_now_tick
// result   | out       | o_valid / i_stall    | o_fired, o_channel, o_flags
//
// One request per cycle unless stalled; its result is registered in the
// next cycle. Nine cells in a priority chain compare in the same cycle.
// Synchronous active-low reset clears all release ticks to zero.
// Requests are stalled only while a result is held by a downstream stall.
module multirate_release_flags_core #(
    parameter int unsigned TICK_RATE    = mrf_pkg::TICK_RATE_DEF,
    parameter int unsigned NUM_CHANNELS = mrf_pkg::NUM_CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_op,
    input  logic [mrf_pkg::TICK_W-1:0]  i_now_tick,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_fired,
    output logic [mrf_pkg::CHAN_W-1:0]  o_channel,
    output logic [mrf_pkg::FLAG_W-1:0]  o_flags
);
    import mrf_pkg::*;

    logic               accept;
    t_cell_ctrl         ctrl;
    logic [RATE_COUNT:0] claim;
    logic [FLAG_W-1:0]  hit;
    logic [CHAN_W-1:0]  chan;

    logic               r_out_valid;
    logic               r_fired;
    logic [CHAN_W-1:0]  r_channel;
    logic [FLAG_W-1:0]  r_flags;

    assign o_stall   = r_out_valid && i_stall;
    assign accept    = i_valid && !o_stall;
    assign ctrl.load = accept && (t_op'(i_op) == OP_INIT);
    assign ctrl.run  = accept && (t_op'(i_op) == OP_RUN);
    assign claim[0]  = 1'b0;

    for (genvar g = 0; g < RATE_COUNT; g++) begin : g_cell
        localparam int unsigned      PER_INT = TICK_RATE / RATE_TABLE[g];
        localparam logic [TICK_W-1:0] PER    = TICK_W'(PER_INT);
        localparam bit               ACT     = (g < NUM_CHANNELS);

        mrf_cell #(
            .PERIOD (PER),
            .ACTIVE (ACT)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_now_tick (i_now_tick),
            .i_claim    (claim[g]),
            .o_claim    (claim[g+1]),
            .o_hit      (hit[g])
        );
    end

    always_comb begin
        chan = '0;
        for (int i = 0; i < RATE_COUNT; i++) begin
            if (hit[i]) begin
                chan = chan | CHAN_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fired   <= claim[RATE_COUNT];
            r_channel <= chan;
            r_flags   <= hit;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_fired   = r_fired;
    assign o_channel = r_channel;
    assign o_flags   = r_flags;

    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0(o_flags))
        else $error("release flags not one-hot");

    a_fired_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fired == (|o_flags)))
        else $error("fired bit disagrees with flags");

    a_channel_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fired) |-> ((FLAG_W'(1) << o_channel) == o_flags))
        else $error("channel index disagrees with flags");

    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (t_op'(i_op) == OP_INIT)) |=> (o_valid && !o_fired && (o_flags == '0)))
        else $error("init request released a channel");

endmodule

FILE: rtl/mrf_cell.sv
`timescale 1ns / 1ps

module mrf_cell #(
    parameter logic [mrf_pkg::TICK_W-1:0] PERIOD = '0,
    parameter bit                         ACTIVE = 1'b1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mrf_pkg::t_cell_ctrl         i_ctrl,
    input  logic [mrf_pkg::TICK_W-1:0]  i_now_tick,
    input  logic                        i_claim,
    output logic                        o_claim,
    output logic                        o_hit
);
    import mrf_pkg::*;

    logic [TICK_W-1:0] r_release_tick;
    logic [TICK_W-1:0] n_release_tick;
    logic [TICK_W-1:0] elapsed;
    logic              due;

    assign elapsed = i_now_tick - r_release_tick;
    assign due     = ACTIVE && (elapsed >= PERIOD);
    assign o_hit   = i_ctrl.run && !i_claim && due;
    assign o_claim = i_claim || o_hit;

    always_comb begin
        n_release_tick = r_release_tick;
        if (i_ctrl.load) begin
            n_release_tick = i_now_tick;
        end else if (o_hit) begin
            n_release_tick = r_release_tick + PERIOD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release_tick <= '0;
        end else begin
            r_release_tick <= n_release_tick;
        end
    end

endmodule

FILE: test/mrf_release_checker.sv
`timescale 1ns / 1ps

module mrf_release_checker #(
    parameter int unsigned TICK_RATE    = mrf_pkg::TICK_RATE_DEF,
    parameter int unsigned NUM_CHANNELS = mrf_pkg::NUM_CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_stall,
    input  logic                        i_op,
    input  logic [mrf_pkg::TICK_W-1:0]  i_now_tick,
    input  logic                        i_rsp_valid,
    input  logic                        i_rsp_stall,
    input  logic                        i_fired,
    input  logic [mrf_pkg::CHAN_W-1:0]  i_channel,
    input  logic [mrf_pkg::FLAG_W-1:0]  i_flags,
    output int                          o_fail_count,
    output int                          o_pending
);
    import mrf_pkg::*;

    localparam int unsigned LIVE_CHANNELS =
        (NUM_CHANNELS > RATE_COUNT) ? RATE_COUNT : NUM_CHANNELS;

    typedef struct packed {
        logic              fired;
        logic [CHAN_W-1:0] channel;
        logic [FLAG_W-1:0] flags;
    } t_release;

    logic [TICK_W-1:0] last_release [RATE_COUNT];
    t_release          due_release_q [$];
    int                mismatch_count = 0;

    // fastest channel that is due wins; its release tick steps one period
    task automatic predict_release(input t_op op, input logic [TICK_W-1:0] now,
                                   output t_release res);
        logic [TICK_W-1:0] period;
        logic [TICK_W-1:0] elapsed;
        logic              done;
        res  = '0;
        done = 1'b0;
        if (op == OP_INIT) begin
            for (int i = 0; i < RATE_COUNT; i++) last_release[i] = now;
        end else begin
            for (int i = 0; i < LIVE_CHANNELS; i++) begin
                period  = TICK_W'(TICK_RATE / RATE_TABLE[i]);
                elapsed = now - last_release[i];
                if (!done && elapsed >= period) begin
                    last_release[i] = last_release[i] + period;
                    res.fired       = 1'b1;
                    res.channel     = CHAN_W'(i);
                    res.flags       = FLAG_W'(1) << i;
                    done            = 1'b1;
                end
            end
        end
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (mismatch_count < 10) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_release want;
        t_release got;
        if (!i_rst_n) begin
            foreach (last_release[i]) last_release[i] = '0;
            due_release_q.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                got = {i_fired, i_channel, i_flags};
                if (due_release_q.size() == 0) begin
                    note_mismatch("unrequested result", '0, 32'(got));
                end else begin
                    want = due_release_q.pop_front();
                    if (got.fired !== want.fired)
                        note_mismatch("fired", 32'(want.fired), 32'(got.fired));
                    if (got.channel !== want.channel)
                        note_mismatch("channel", 32'(want.channel), 32'(got.channel));
                    if (got.flags !== want.flags)
                        note_mismatch("flags", 32'(want.flags), 32'(got.flags));
                end
            end
            if (i_req_valid && !i_req_stall) begin
                predict_release(t_op'(i_op), i_now_tick, want);
                due_release_q.push_back(want);
            end
        end
        o_pending    = due_release_q.size();
        o_fail_count = mismatch_count;
    end

endmodule

FILE: test/multirate_release_flags_core_tb.sv
`timescale 1ns / 1ps

module multirate_release_flags_core_tb;
    import mrf_pkg::*;

    localparam int unsigned TB_TICK_RATE    = TICK_RATE_DEF;
    localparam int unsigned TB_NUM_CHANNELS = NUM_CHANNELS_DEF;
    localparam int unsigned LIVE_CHANNELS   =
        (TB_NUM_CHANNELS > RATE_COUNT) ? RATE_COUNT : TB_NUM_CHANNELS;
    localparam int          STALL_PCT       = 16;
    localparam int          WATCHDOG_LIMIT  = 2000;
    localparam int          HAUL_TICKS      = 260;
    localparam int          REQ_TARGET      = 1400;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_op;
    logic [TICK_W-1:0] i_now_tick;
    logic              o_valid;
    logic              i_stall;
    logic              o_fired;
    logic [CHAN_W-1:0] o_channel;
    logic [FLAG_W-1:0] o_flags;

    int                fail_count;
    int                pending;
    logic              quiet;
    int                req_count;
    int                idle_cycles;
    logic [TICK_W-1:0] cur_tick;

    multirate_release_flags_core #(
        .TICK_RATE    (TB_TICK_RATE),
        .NUM_CHANNELS (TB_NUM_CHANNELS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_op       (i_op),
        .i_now_tick (i_now_tick),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_fired    (o_fired),
        .o_channel  (o_channel),
        .o_flags    (o_flags)
    );

    mrf_release_checker #(
        .TICK_RATE    (TB_TICK_RATE),
        .NUM_CHANNELS (TB_NUM_CHANNELS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_op         (i_op),
        .i_now_tick   (i_now_tick),
        .i_rsp_valid  (o_valid),
        .i_rsp_stall  (i_stall),
        .i_fired      (o_fired),
        .i_channel    (o_channel),
        .i_flags      (o_flags),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= !quiet && ($urandom_range(99) < STALL_PCT);
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[multirate_release_flags_core] ERROR");
        $finish;
    end

    task automatic send_req(input t_op op, input logic [TICK_W-1:0] tick);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < STALL_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_now_tick <= tick;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        req_count++;
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // mostly tick advances followed by catch-up runs; some inits and noise
    task automatic mixed_burst();
        int unsigned pick;
        int unsigned step;
        int unsigned runs;
        pick = $urandom_range(99);
        if (pick < 70) begin
            step = ($urandom_range(3) == 0) ? $urandom_range(60, 5) : $urandom_range(3);
            cur_tick += step;
            runs = $urandom_range(2 * step + 3, 1);
            repeat (runs) send_req(OP_RUN, cur_tick);
        end else if (pick < 85) begin
            case ($urandom_range(2))
                0: cur_tick = $urandom;
                1: cur_tick = {TICK_W{1'b1}} - $urandom_range(40);
                default: cur_tick = cur_tick + $urandom_range(20);
            endcase
            send_req(OP_INIT, cur_tick);
        end else begin
            repeat ($urandom_range(4, 1)) send_req(t_op'($urandom_range(1)), $urandom);
        end
    endtask

    // steady 1 ms ticks long enough for the 4 Hz channel to come due
    task automatic long_haul();
        logic [TICK_W-1:0] base;
        int unsigned       runs;
        int unsigned       period;
        base = $urandom_range(1) ? $urandom : ({TICK_W{1'b1}} - $urandom_range(HAUL_TICKS));
        send_req(OP_INIT, base);
        for (int t = 1; t <= HAUL_TICKS; t++) begin
            quiet = (t >= 60 && t < 180);
            if (t == 200) hold_until_drained();
            runs = 1 + ($urandom_range(15) == 0);
            for (int i = 1; i < LIVE_CHANNELS; i++) begin
                period = TB_TICK_RATE / RATE_TABLE[i];
                if (period != 0 && t % period == 0) runs++;
            end
            repeat (runs) send_req(OP_RUN, base + t);
        end
        quiet    = 1'b0;
        cur_tick = base + HAUL_TICKS;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_op       = OP_INIT;
        i_now_tick = '0;
        quiet      = 1'b0;
        req_count  = 0;
        cur_tick   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // nothing due, first releases, priority between the two fastest
        send_req(OP_RUN, 32'h0000_0000);
        send_req(OP_RUN, 32'h0000_0001);
        send_req(OP_RUN, 32'h0000_0001);
        send_req(OP_RUN, 32'h0000_0002);
        send_req(OP_RUN, 32'h0000_0002);
        send_req(OP_RUN, 32'h0000_0002);
        // tick wrap and backward tick
        send_req(OP_INIT, 32'hFFFF_FFFF);
        send_req(OP_RUN, 32'hFFFF_FFFF);
        send_req(OP_RUN, 32'h0000_0000);
        send_req(OP_RUN, 32'h0000_0000);
        send_req(OP_RUN, 32'hFFFF_FFFE);
        send_req(OP_INIT, 32'h8000_0000);
        send_req(OP_RUN, 32'h7FFF_FFFF);
        send_req(OP_INIT, 32'hAAAA_AAAA);
        send_req(OP_INIT, 32'h5555_5555);
        send_req(OP_RUN, 32'h5555_5555);
        send_req(OP_RUN, 32'h5555_5556);
        send_req(OP_RUN, 32'h5555_5557);
        send_req(OP_RUN, 32'h5555_5557);
        hold_until_drained();

        while (req_count < 200) mixed_burst();
        long_haul();
        while (req_count < REQ_TARGET) mixed_burst();

        hold_until_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[multirate_release_flags_core] OK");
        end else begin
            $display("[multirate_release_flags_core] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/mrf_pkg.sv
rtl/mrf_cell.sv
rtl/multirate_release_flags_core.sv
test/mrf_release_checker.sv
test/multirate_release_flags_core_tb.sv
